@@ src/tpwg_pkg.sv @@
// package for the tracked point window gate
// holds op and outcome codes and the register indexes; no dependencies
`default_nettype none
package tpwg_pkg;
  localparam int unsigned OpW = 2;
  localparam logic [1:0] OP_CAND  = 2'd0;
  localparam logic [1:0] OP_TRACK = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [2:0] OUT_INSERTED = 3'd0;
  localparam logic [2:0] OUT_INSIDE   = 3'd1;
  localparam logic [2:0] OUT_FULL     = 3'd2;
  localparam logic [2:0] OUT_KEPT     = 3'd3;
  localparam logic [2:0] OUT_DROPPED  = 3'd4;
  localparam logic [2:0] OUT_CLOSED   = 3'd5;

  localparam logic [2:0] REG_MIN_RADIUS   = 3'd0;
  localparam logic [2:0] REG_MAX_RADIUS   = 3'd1;
  localparam logic [2:0] REG_MAX_POINTS   = 3'd2;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd3;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;

  localparam int unsigned PosW = 17;
  localparam int unsigned LenW = 16;
  localparam int unsigned CntW = 10;
  localparam int unsigned CfgW = 13;
endpackage
`default_nettype wire

@@ src/tracked_point_window_gate.sv @@
// Tracked point window gate. One request in, one result out. A candidate
// (op 0) scans every live entry, one memory read a cycle; a tracked result
// (op 1) does one read-modify-write; a frame close (op 2) copies the unread
// tail down one entry a cycle. Entry contents are undefined after reset and
// need no clearing pass.
// depends on tpwg_pkg, tpwg_ram and tpwg_circle
`default_nettype none
module tracked_point_window_gate #(
  parameter int unsigned TableDepth = 512,
  parameter int unsigned FracBits   = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 op_i,
  input  wire logic signed [16:0]         pos_x_i,
  input  wire logic signed [16:0]         pos_y_i,
  input  wire logic                       track_ok_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [2:0]                      outcome_o,
  output logic [9:0]                      slot_o,
  output logic [9:0]                      point_count_o,
  output logic                            keyframe_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [2:0]                 cfg_index_i,
  input  wire logic [12:0]                cfg_data_i
);
  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned PW = tpwg_pkg::PosW;
  localparam int unsigned LW = tpwg_pkg::LenW;
  localparam int unsigned EW = 2*PW + LW;
  localparam int unsigned XW = AW + 2;   // pointer width, holds depth
  localparam int unsigned Lat = 3;       // read plus two compare stages

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TRACK_RD, S_TRACK_WR, S_COPY, S_OUT
  } state_e;

  state_e state_q;
  logic [7:0]  min_r_q, max_r_q;
  logic [9:0]  max_pts_q;
  logic [12:0] fw_q, fh_q;
  logic [XW-1:0] cnt_q, rp_q, wp_q, kf_q;
  logic [PW-1:0] cx_q, cy_q;
  logic          ok_q;
  logic [XW-1:0] idx_q, src_q;
  logic [Lat-1:0] pv_q;
  logic           hit_q;
  logic [2:0] outcome_q;
  logic [9:0] slot_q, pc_q;
  logic       key_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic          covers;

  tpwg_ram #(.Width(EW), .Depth(TableDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  tpwg_circle #(.FracBits(FracBits)) u_circle (
    .clk_i,
    .ent_x_i(rdata[EW-1 -: PW]), .ent_y_i(rdata[LW+PW-1 -: PW]),
    .ent_len_i(rdata[LW-1:0]), .cand_x_i(cx_q), .cand_y_i(cy_q),
    .min_radius_i(min_r_q), .max_radius_i(max_r_q), .covers_o(covers)
  );

  logic [XW-1:0] live;
  logic          in_req;
  logic          scan_issue;
  logic [XW-1:0] n_abs_d;
  logic [XW+2:0] five_d;
  logic          inb;
  logic [LW-1:0] len_inc;

  // live count, scan order, bounds and keyframe arithmetic
  always_comb begin
    live       = wp_q + cnt_q - rp_q;
    in_req     = in_valid_i && in_ready_o;
    scan_issue = (idx_q < wp_q) || ((idx_q >= rp_q) && (idx_q < cnt_q));
    n_abs_d    = (kf_q > live) ? kf_q - live : live - kf_q;
    five_d     = (XW+3)'(n_abs_d) * (XW+3)'(5);
    inb = ok_q && !cx_q[PW-1] && !cy_q[PW-1]
          && ({1'b0, cx_q} < ((PW+1)'(fw_q) << FracBits))
          && ({1'b0, cy_q} < ((PW+1)'(fh_q) << FracBits));
    len_inc = (rdata[LW-1:0] == {LW{1'b1}}) ? rdata[LW-1:0] : rdata[LW-1:0] + 1'b1;
  end

  // memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = wp_q[AW-1:0];
    wdata = {cx_q, cy_q, len_inc};
    raddr = idx_q[AW-1:0];
    case (state_q)
      S_TRACK_RD: raddr = rp_q[AW-1:0];
      S_TRACK_WR: we = inb;
      S_COPY: begin
        raddr = src_q[AW-1:0];
        we    = pv_q[0];
        waddr = idx_q[AW-1:0];
        wdata = rdata;
      end
      S_SCAN: begin
        if (pv_q == '0 && idx_q >= cnt_q && !hit_q) begin
          we    = 1'b1;
          waddr = cnt_q[AW-1:0];
          wdata = {cx_q, cy_q, LW'(1)};
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o    = state_q == S_IDLE;
  assign out_valid_o   = state_q == S_OUT;
  assign outcome_o     = outcome_q;
  assign slot_o        = slot_q;
  assign point_count_o = pc_q;
  assign keyframe_o    = key_q;

  // configuration, control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      min_r_q <= 8'd5; max_r_q <= 8'd30; max_pts_q <= 10'd512;
      fw_q <= 13'd640; fh_q <= 13'd480;
      cnt_q <= '0; rp_q <= '0; wp_q <= '0; kf_q <= '0;
      pv_q <= '0; hit_q <= 1'b0;
      outcome_q <= tpwg_pkg::OUT_DROPPED; slot_q <= '0; pc_q <= '0; key_q <= 1'b0;
      cx_q <= '0; cy_q <= '0; ok_q <= 1'b0; idx_q <= '0; src_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tpwg_pkg::REG_MIN_RADIUS:   min_r_q   <= cfg_data_i[7:0];
          tpwg_pkg::REG_MAX_RADIUS:   max_r_q   <= cfg_data_i[7:0];
          tpwg_pkg::REG_MAX_POINTS:   max_pts_q <= cfg_data_i[9:0];
          tpwg_pkg::REG_FRAME_WIDTH:  fw_q      <= cfg_data_i;
          tpwg_pkg::REG_FRAME_HEIGHT: fh_q      <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_req) begin
            cx_q <= pos_x_i; cy_q <= pos_y_i; ok_q <= track_ok_i;
            slot_q <= '0; key_q <= 1'b0;
            pc_q <= live[9:0];
            pv_q <= '0; hit_q <= 1'b0;
            case (op_i)
              tpwg_pkg::OP_CAND: begin
                // start at the unread entries when nothing has been kept
                idx_q <= (wp_q == '0) ? rp_q : '0;
                if (live >= XW'(max_pts_q) || cnt_q >= XW'(TableDepth)) begin
                  outcome_q <= tpwg_pkg::OUT_FULL;
                  state_q   <= S_OUT;
                end else begin
                  outcome_q <= tpwg_pkg::OUT_DROPPED;
                  state_q   <= S_SCAN;
                end
              end
              tpwg_pkg::OP_TRACK: begin
                outcome_q <= tpwg_pkg::OUT_DROPPED;
                state_q   <= (rp_q < cnt_q) ? S_TRACK_RD : S_OUT;
              end
              tpwg_pkg::OP_CLOSE: begin
                outcome_q <= tpwg_pkg::OUT_DROPPED;
                idx_q <= wp_q; src_q <= rp_q;
                state_q <= S_COPY;
              end
              default: begin
                outcome_q <= tpwg_pkg::OUT_DROPPED;
                state_q   <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          // issue one read a cycle while entries remain, collect hits
          pv_q <= {scan_issue && idx_q < cnt_q, pv_q[Lat-1:1]};
          if (pv_q[0] && covers) hit_q <= 1'b1;
          if (idx_q < cnt_q) begin
            idx_q <= (idx_q < wp_q && wp_q <= rp_q && idx_q + 1'b1 == wp_q)
                     ? rp_q : idx_q + 1'b1;
          end else if (pv_q == '0) begin
            if (hit_q) begin
              outcome_q <= tpwg_pkg::OUT_INSIDE;
            end else begin
              outcome_q <= tpwg_pkg::OUT_INSERTED;
              slot_q    <= cnt_q[9:0];
              cnt_q     <= cnt_q + 1'b1;
              pc_q      <= 10'(live + 1'b1);
            end
            state_q <= S_OUT;
          end
        end
        S_TRACK_RD: state_q <= S_TRACK_WR;
        S_TRACK_WR: begin
          rp_q <= rp_q + 1'b1;
          if (inb) begin
            outcome_q <= tpwg_pkg::OUT_KEPT;
            slot_q    <= wp_q[9:0];
            wp_q      <= wp_q + 1'b1;
          end else begin
            pc_q <= 10'(live - 1'b1);
          end
          state_q <= S_OUT;
        end
        S_COPY: begin
          // move unread tail down behind the kept entries
          pv_q <= {Lat{1'b0}} | Lat'(src_q < cnt_q && rp_q > wp_q);
          if (src_q < cnt_q && rp_q > wp_q) begin
            src_q <= src_q + 1'b1;
          end
          if (pv_q[0]) idx_q <= idx_q + 1'b1;
          if (!(src_q < cnt_q && rp_q > wp_q) && !pv_q[0]) begin
            cnt_q <= live; rp_q <= '0; wp_q <= '0;
            outcome_q <= tpwg_pkg::OUT_CLOSED;
            pc_q <= live[9:0];
            if (five_d >= (XW+3)'(kf_q)) begin
              kf_q  <= live;
              key_q <= 1'b1;
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/tpwg_ram.sv @@
// generic simple dual port synchronous ram with registered read
// no dependencies
`default_nettype none
module tpwg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ src/tpwg_circle.sv @@
// window test of one stored entry against a candidate, two register stages
// depends on tpwg_pkg
`default_nettype none
module tpwg_circle #(
  parameter int unsigned FracBits = 4
) (
  input  wire logic                        clk_i,
  input  wire logic [tpwg_pkg::PosW-1:0]   ent_x_i,
  input  wire logic [tpwg_pkg::PosW-1:0]   ent_y_i,
  input  wire logic [tpwg_pkg::LenW-1:0]   ent_len_i,
  input  wire logic [tpwg_pkg::PosW-1:0]   cand_x_i,
  input  wire logic [tpwg_pkg::PosW-1:0]   cand_y_i,
  input  wire logic [7:0]                  min_radius_i,
  input  wire logic [7:0]                  max_radius_i,
  output logic                             covers_o
);
  localparam int unsigned DW = tpwg_pkg::PosW + 1;
  localparam int unsigned RW = 8 + FracBits;

  logic signed [DW-1:0] dx, dy;
  logic [7:0]           rad;
  logic [DW-1:0]        adx_q, ady_q;
  logic [RW-1:0]        rs_q;
  logic [2*DW-1:0]      sq_x, sq_y;
  logic [2*DW:0]        dist_sq;
  logic [2*RW-1:0]      rsq;

  // difference and radius clamp
  always_comb begin
    dx = DW'($signed(ent_x_i)) - DW'($signed(cand_x_i));
    dy = DW'($signed(ent_y_i)) - DW'($signed(cand_y_i));
    if (ent_len_i > {8'd0, max_radius_i}) begin
      rad = max_radius_i;
    end else if (ent_len_i < {8'd0, min_radius_i}) begin
      rad = min_radius_i;
    end else begin
      rad = ent_len_i[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q <= dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady_q <= dy[DW-1] ? DW'(-dy) : DW'(dy);
    rs_q  <= RW'(rad) << FracBits;
  end

  // squares and compare
  always_comb begin
    sq_x    = adx_q * adx_q;
    sq_y    = ady_q * ady_q;
    dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
    rsq     = rs_q * rs_q;
  end

  always_ff @(posedge clk_i) begin
    covers_o <= dist_sq <= (2*DW+1)'(rsq);
  end
endmodule
`default_nettype wire

@@ sim/tb_tracked_point_window_gate.sv @@
// testbench for the tracked point window gate: random and directed requests,
// results checked against a behavioural table model kept in the bench
// depends on tpwg_pkg and tracked_point_window_gate
`default_nettype none
module tb_tracked_point_window_gate;

  localparam int Depth = 512;
  localparam int Limit = 4000000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic               ok;
  } request_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [9:0] slot;
    logic [9:0] count;
    logic       key;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = '0;
  logic signed [16:0] pos_x_i = '0;
  logic signed [16:0] pos_y_i = '0;
  logic track_ok_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] outcome_o;
  logic [9:0] slot_o;
  logic [9:0] point_count_o;
  logic keyframe_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;

  tracked_point_window_gate dut (.*);

  // bench copy of the table and registers
  int unsigned min_rad, max_rad, point_limit, width_px, height_px;
  int tab_x [Depth];
  int tab_y [Depth];
  int unsigned tab_len [Depth];
  int unsigned n_entries, rd_ptr, wr_ptr, key_count;

  request_t pending_requests[$];
  verdict_t expected_verdicts[$];
  int mismatches = 0;
  int cycles = 0;
  bit hold_sender = 1'b0;
  bit in_taken = 1'b0;

  function automatic int unsigned live_points();
    return wr_ptr + n_entries - rd_ptr;
  endfunction

  function automatic bit in_window(int unsigned s, int px, int py);
    int unsigned r;
    longint dx, dy, rs;
    r = tab_len[s];
    if (r > max_rad) r = max_rad;
    else if (r < min_rad) r = min_rad;
    dx = longint'(tab_x[s]) - px;
    dy = longint'(tab_y[s]) - py;
    rs = longint'(r) * 16;
    return dx * dx + dy * dy <= rs * rs;
  endfunction

  function automatic verdict_t gate_point(request_t rq);
    verdict_t v;
    int px, py, m;
    int unsigned len, n, k, d;
    bit hit;
    px = rq.x;
    py = rq.y;
    v = '{outcome: tpwg_pkg::OUT_DROPPED, slot: '0, count: '0, key: 1'b0};
    if (rq.op == tpwg_pkg::OP_CAND) begin
      if (live_points() >= point_limit || n_entries >= Depth) begin
        v.outcome = tpwg_pkg::OUT_FULL;
      end else begin
        hit = 1'b0;
        for (int s = 0; s < wr_ptr; s++) if (in_window(s, px, py)) hit = 1'b1;
        for (int s = rd_ptr; s < n_entries; s++) if (in_window(s, px, py)) hit = 1'b1;
        if (hit) begin
          v.outcome = tpwg_pkg::OUT_INSIDE;
        end else begin
          v.slot = 10'(n_entries);
          tab_x[n_entries] = px;
          tab_y[n_entries] = py;
          tab_len[n_entries] = 1;
          n_entries++;
          v.outcome = tpwg_pkg::OUT_INSERTED;
        end
      end
    end else if (rq.op == tpwg_pkg::OP_TRACK) begin
      if (rd_ptr < n_entries) begin
        if (rq.ok && px >= 0 && py >= 0 && px < width_px * 16 && py < height_px * 16) begin
          len = tab_len[rd_ptr];
          if (len < 65535) len++;
          v.slot = 10'(wr_ptr);
          tab_x[wr_ptr] = px;
          tab_y[wr_ptr] = py;
          tab_len[wr_ptr] = len;
          wr_ptr++;
          v.outcome = tpwg_pkg::OUT_KEPT;
        end
        rd_ptr++;
      end
    end else if (rq.op == tpwg_pkg::OP_CLOSE) begin
      n = live_points();
      k = key_count;
      d = (k > n) ? k - n : n - k;
      // move unread tail down behind the kept entries
      if (rd_ptr > wr_ptr && n_entries > rd_ptr) begin
        m = n_entries - rd_ptr;
        for (int i = 0; i < m; i++) begin
          tab_x[wr_ptr + i] = tab_x[rd_ptr + i];
          tab_y[wr_ptr + i] = tab_y[rd_ptr + i];
          tab_len[wr_ptr + i] = tab_len[rd_ptr + i];
        end
      end
      n_entries = n;
      rd_ptr = 0;
      wr_ptr = 0;
      if (5 * d >= k) begin
        key_count = n;
        v.key = 1'b1;
      end
      v.outcome = tpwg_pkg::OUT_CLOSED;
    end
    v.count = 10'(live_points());
    return v;
  endfunction

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // driver: bursts and gaps, inputs change on the falling edge
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        // request taken at the last rising edge
        void'(pending_requests.pop_front());
      end
      if (in_valid_i && !in_taken) begin
        // hold request until taken
      end else if (pending_requests.size() == 0 || hold_sender) begin
        in_valid_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        op_i <= pending_requests[0].op;
        pos_x_i <= pending_requests[0].x;
        pos_y_i <= pending_requests[0].y;
        track_ok_i <= pending_requests[0].ok;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      // receiver stall pattern
      out_ready_i <= ((cycles / 200) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // predictor fed at each accepted request; monitor checks each result
  always @(posedge clk_i) begin
    verdict_t got, want;
    cycles <= cycles + 1;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_verdicts.insert(expected_verdicts.size(),
                               gate_point(request_t'{op: op_i, x: pos_x_i, y: pos_y_i,
                                                     ok: track_ok_i}));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{outcome: outcome_o, slot: slot_o, count: point_count_o, key: keyframe_o};
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (cycles > Limit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_request(logic [1:0] op, int x, int y, bit ok);
    pending_requests.insert(pending_requests.size(),
                            request_t'{op: op, x: x[16:0], y: y[16:0], ok: ok});
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[12:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tpwg_pkg::REG_MIN_RADIUS: min_rad = val & 8'hff;
      tpwg_pkg::REG_MAX_RADIUS: max_rad = val & 8'hff;
      tpwg_pkg::REG_MAX_POINTS: point_limit = val & 10'h3ff;
      tpwg_pkg::REG_FRAME_WIDTH: width_px = val & 13'h1fff;
      default: height_px = val & 13'h1fff;
    endcase
  endtask

  // one frame: a few candidates, tracks for the old ones, then on most frames a close
  task automatic queue_frame(int cands, int tracks);
    int r;
    for (int i = 0; i < cands; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) add_request(tpwg_pkg::OP_CAND, $urandom_range(0, 131071) - 65536,
                              $urandom_range(0, 131071) - 65536, $urandom_range(0, 1));
      else add_request(tpwg_pkg::OP_CAND, $urandom_range(0, width_px * 16 + 40),
                       $urandom_range(0, height_px * 16 + 40), $urandom_range(0, 1));
    end
    for (int i = 0; i < tracks; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) add_request(tpwg_pkg::OP_TRACK, $urandom_range(0, 131071) - 65536,
                              $urandom_range(0, 131071) - 65536, $urandom_range(0, 1));
      else add_request(tpwg_pkg::OP_TRACK, $urandom_range(0, width_px * 16 + 20) - 10,
                       $urandom_range(0, height_px * 16 + 20) - 10, r != 1);
    end
    if ($urandom_range(0, 7) != 0)
      add_request(tpwg_pkg::OP_CLOSE, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  initial begin
    min_rad = 5; max_rad = 30; point_limit = 512; width_px = 640; height_px = 480;
    n_entries = 0; rd_ptr = 0; wr_ptr = 0; key_count = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every op, empty track, radius clamp, full table
    add_request(tpwg_pkg::OP_TRACK, 0, 0, 1'b1);
    add_request(tpwg_pkg::OP_CLOSE, 0, 0, 1'b0);
    add_request(tpwg_pkg::OP_CAND, -65536, -65536, 1'b0);
    add_request(tpwg_pkg::OP_CAND, 65535, 65535, 1'b1);
    add_request(tpwg_pkg::OP_CAND, 65535 - 80, 65535, 1'b0);
    add_request(tpwg_pkg::OP_CAND, 65535 - 81, 65535, 1'b0);
    add_request(tpwg_pkg::OP_CAND, 0, 0, 1'b0);
    add_request(tpwg_pkg::OP_TRACK, -1, 0, 1'b1);
    add_request(tpwg_pkg::OP_TRACK, 10239, 7679, 1'b1);
    add_request(tpwg_pkg::OP_TRACK, 10240, 0, 1'b1);
    add_request(tpwg_pkg::OP_TRACK, 5, 5, 1'b0);
    add_request(tpwg_pkg::OP_TRACK, 0, 7680, 1'b1);
    add_request(tpwg_pkg::OP_CLOSE, 0, 0, 1'b1);
    add_request(tpwg_pkg::OP_TRACK, 0, 0, 1'b1);
    add_request(tpwg_pkg::OP_CLOSE, -1, -1, 1'b1);
    add_request(tpwg_pkg::OP_SPARE, 100, 100, 1'b1);
    drain();

    write_reg(tpwg_pkg::REG_MIN_RADIUS, 40);
    write_reg(tpwg_pkg::REG_MAX_RADIUS, 3);
    write_reg(tpwg_pkg::REG_MAX_POINTS, 2);
    add_request(tpwg_pkg::OP_CAND, 2000, 2000, 1'b0);
    add_request(tpwg_pkg::OP_CAND, 2639, 2000, 1'b0);
    add_request(tpwg_pkg::OP_CAND, 2641, 2000, 1'b0);
    add_request(tpwg_pkg::OP_CAND, 9000, 2000, 1'b0);
    drain();

    // random phases across settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(tpwg_pkg::REG_MIN_RADIUS, 0);
                 write_reg(tpwg_pkg::REG_MAX_RADIUS, 255);
                 write_reg(tpwg_pkg::REG_MAX_POINTS, 512);
                 write_reg(tpwg_pkg::REG_FRAME_WIDTH, 4096);
                 write_reg(tpwg_pkg::REG_FRAME_HEIGHT, 4096); end
        1: begin write_reg(tpwg_pkg::REG_MIN_RADIUS, 255);
                 write_reg(tpwg_pkg::REG_MAX_RADIUS, 0);
                 write_reg(tpwg_pkg::REG_FRAME_WIDTH, 1);
                 write_reg(tpwg_pkg::REG_FRAME_HEIGHT, 1); end
        2: begin write_reg(tpwg_pkg::REG_MIN_RADIUS, 5);
                 write_reg(tpwg_pkg::REG_MAX_RADIUS, 30);
                 write_reg(tpwg_pkg::REG_MAX_POINTS, 1);
                 write_reg(tpwg_pkg::REG_FRAME_WIDTH, 640);
                 write_reg(tpwg_pkg::REG_FRAME_HEIGHT, 480); end
        default: begin
          write_reg(tpwg_pkg::REG_MIN_RADIUS, $urandom_range(0, 8));
          write_reg(tpwg_pkg::REG_MAX_RADIUS, $urandom_range(0, 20));
          write_reg(tpwg_pkg::REG_MAX_POINTS, $urandom_range(1, 512));
          write_reg(tpwg_pkg::REG_FRAME_WIDTH, $urandom_range(1, 700));
          write_reg(tpwg_pkg::REG_FRAME_HEIGHT, $urandom_range(1, 500));
        end
      endcase
      for (int f = 0; f < 8; f++) queue_frame($urandom_range(0, 18), $urandom_range(0, 16));
      if (ph == 4) begin
        // sender waits for every outstanding result
        while (pending_requests.size() > 6) @(posedge clk_i);
        hold_sender = 1'b1;
        while (in_valid_i || expected_verdicts.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
        hold_sender = 1'b0;
      end
      drain();
    end
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
src/tpwg_pkg.sv
src/tpwg_ram.sv
src/tpwg_circle.sv
src/tracked_point_window_gate.sv
sim/tb_tracked_point_window_gate.sv
